[src/slcd_pkg.sv]
// Shared constants for the sync/length/checksum deframer.
package slcd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  // Reset value of the sync byte register.
  localparam logic [ByteW-1:0] SyncReset = 8'h68;

  // Event codes on the result channel.
  localparam logic [KindW-1:0] EvPayload     = 2'd0;
  localparam logic [KindW-1:0] EvAccept      = 2'd1;
  localparam logic [KindW-1:0] EvChecksumErr = 2'd2;
  localparam logic [KindW-1:0] EvSequenceErr = 2'd3;

endpackage

[src/slcd_in_if.sv]
// Byte request channel into the deframer.
interface slcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [slcd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/slcd_out_if.sv]
// Event request channel out of the deframer.
interface slcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [slcd_pkg::KindW-1:0]  event_kind;
  logic [slcd_pkg::ByteW-1:0]  payload_byte;
  logic [slcd_pkg::ByteW-1:0]  frame_address;
  logic [slcd_pkg::ByteW-1:0]  payload_index;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_address, output payload_index, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input frame_address, input payload_index, output ready);
endinterface

[src/sync_length_checksum_deframer.sv]
// Sync/length/checksum deframer: hunts for a sync byte, then parses one frame.
//
// Bytes enter one request per cycle on rx_i. While hunting, every byte is
// dropped until one equals the sync register; the next byte is the frame
// length L (counting itself, the address, the payload and the checksum), then
// the address, then L-3 payload bytes, then the checksum (8-bit sum of L, the
// address and the payload). Each payload byte leaves on ev_o as a payload
// event with its zero-based index; the checksum byte gives frame accepted or
// checksum error with the payload count. A length below 3 gives a sequence
// error on the byte after the address. Any frame end returns to hunting, and
// a sync value inside a frame is plain data. Throughput is one byte per cycle
// while ev_o is not holding an event back; a byte passes through the input
// register and its event, if any, through the output register. A stalled
// ev_o holds its event; bytes that make no event keep flowing, and the next
// byte that makes one waits in the input register until ev_o is taken.
// cfg_we_i/cfg_data_i write the sync byte and must only be used while no
// byte is in flight.
module sync_length_checksum_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [slcd_pkg::ByteW-1:0]  cfg_data_i,
  slcd_in_if.sink                     rx_i,
  slcd_out_if.source                  ev_o
);

  // Parser phases.
  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhLength  = 2'd1;
  localparam logic [1:0] PhAddress = 2'd2;
  localparam logic [1:0] PhBody    = 2'd3;

  logic [slcd_pkg::ByteW-1:0] sync_q;

  // Input register.
  logic                       in_vld_q;
  logic [slcd_pkg::ByteW-1:0] in_byte_q;

  // Frame state.
  logic [1:0]                 phase_q, phase_d;
  logic [slcd_pkg::ByteW-1:0] len_q, len_d;
  logic [slcd_pkg::ByteW-1:0] remain_q, remain_d;
  logic [slcd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [slcd_pkg::ByteW-1:0] addr_q, addr_d;
  logic [slcd_pkg::ByteW-1:0] count_q, count_d;

  // Output register.
  logic                       out_vld_q;
  logic [slcd_pkg::KindW-1:0] out_kind_q, kind_d;
  logic [slcd_pkg::ByteW-1:0] out_byte_q, byte_d;
  logic [slcd_pkg::ByteW-1:0] out_addr_q;
  logic [slcd_pkg::ByteW-1:0] out_index_q, index_d;

  logic emit;      // byte in the input register produces an event
  logic out_free;  // output register can take a new event this cycle
  logic proc;      // input register byte is consumed this cycle
  logic in_take;

  assign out_free = !out_vld_q || ev_o.ready;
  assign proc     = in_vld_q && (!emit || out_free);
  assign in_take  = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !in_vld_q || proc;

  // Per-byte parse step.
  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    addr_d   = addr_q;
    count_d  = count_q;
    emit     = 1'b0;
    kind_d   = slcd_pkg::EvPayload;
    byte_d   = '0;
    index_d  = count_q;
    unique case (phase_q)
      PhLength: begin
        len_d   = in_byte_q;
        sum_d   = in_byte_q;
        count_d = '0;
        phase_d = PhAddress;
      end
      PhAddress: begin
        addr_d   = in_byte_q;
        sum_d    = sum_q + in_byte_q;
        remain_d = (len_q >= 8'd2) ? len_q - 8'd2 : '0;
        phase_d  = PhBody;
      end
      PhBody: begin
        emit = 1'b1;
        priority if (remain_q > 8'd1) begin
          kind_d   = slcd_pkg::EvPayload;
          byte_d   = in_byte_q;
          sum_d    = sum_q + in_byte_q;
          count_d  = count_q + 8'd1;
          remain_d = remain_q - 8'd1;
        end else if (remain_q == 8'd1) begin
          // Checksum byte closes the frame.
          kind_d   = (sum_q == in_byte_q) ? slcd_pkg::EvAccept
                                          : slcd_pkg::EvChecksumErr;
          remain_d = '0;
          phase_d  = PhHunt;
        end else begin
          // Length too short to hold a checksum.
          kind_d  = slcd_pkg::EvSequenceErr;
          phase_d = PhHunt;
        end
      end
      default: begin
        if (in_byte_q == sync_q) begin
          phase_d  = PhLength;
          len_d    = '0;
          remain_d = '0;
          count_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= slcd_pkg::SyncReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      len_q    <= '0;
      remain_q <= '0;
      sum_q    <= '0;
      addr_q   <= '0;
      count_q  <= '0;
    end else if (proc) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      addr_q   <= addr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= proc && emit;
    end
  end

  // Address is unchanged in the body phase, so the registered copy is current.
  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_kind_q  <= kind_d;
      out_byte_q  <= byte_d;
      out_addr_q  <= addr_q;
      out_index_q <= index_d;
    end
  end

  assign ev_o.valid         = out_vld_q;
  assign ev_o.event_kind    = out_kind_q;
  assign ev_o.payload_byte  = out_byte_q;
  assign ev_o.frame_address = out_addr_q;
  assign ev_o.payload_index = out_index_q;

endmodule

[tb/testbench.sv]
// Self-checking bench for the sync/length/checksum deframer: frame tracker and stimulus.
`timescale 1ns / 1ps

typedef struct packed {
  logic [slcd_pkg::KindW-1:0] kind;
  logic [slcd_pkg::ByteW-1:0] data;
  logic [slcd_pkg::ByteW-1:0] addr;
  logic [slcd_pkg::ByteW-1:0] index;
} frame_event_t;

typedef enum logic [1:0] {
  PhHunt,
  PhLength,
  PhAddress,
  PhBody
} deframe_phase_e;

// Tracks the deframer from the accepted byte stream and holds the events still due.
class deframe_tracker;
  logic [7:0]     sync_value;
  deframe_phase_e phase;
  logic [7:0]     frame_len;
  logic [7:0]     left;       // payload bytes still due, plus one for the checksum
  logic [7:0]     sum;
  logic [7:0]     addr;
  logic [7:0]     count;
  frame_event_t   pending_events[$];
  int unsigned    errors;
  int unsigned    reported;
  int unsigned    bytes_seen;
  int unsigned    kind_seen[4];

  function new();
    sync_value = slcd_pkg::SyncReset;
    phase      = PhHunt;
    frame_len  = '0;
    left       = '0;
    sum        = '0;
    addr       = '0;
    count      = '0;
    errors     = 0;
    reported   = 0;
    bytes_seen = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
  endfunction

  function void note_rx_byte(logic [7:0] b);
    frame_event_t e;
    e = '0;
    bytes_seen++;
    case (phase)
      PhLength: begin
        frame_len = b;
        sum       = b;
        count     = '0;
        phase     = PhAddress;
      end
      PhAddress: begin
        addr  = b;
        sum   = sum + b;
        left  = (frame_len >= 8'd2) ? frame_len - 8'd2 : 8'd0;
        phase = PhBody;
      end
      PhBody: begin
        e.addr  = addr;
        e.index = count;
        if (left > 8'd1) begin
          e.kind = slcd_pkg::EvPayload;
          e.data = b;
          sum    = sum + b;
          count  = count + 8'd1;
          left   = left - 8'd1;
        end else if (left == 8'd1) begin
          left   = '0;
          phase  = PhHunt;
          e.kind = (sum == b) ? slcd_pkg::EvAccept : slcd_pkg::EvChecksumErr;
        end else begin
          // length too short to hold a checksum
          phase  = PhHunt;
          e.kind = slcd_pkg::EvSequenceErr;
        end
        pending_events.push_back(e);
      end
      default: begin
        phase = PhHunt;
        if (b == sync_value) begin
          phase     = PhLength;
          frame_len = '0;
          left      = '0;
          count     = '0;
        end
      end
    endcase
  endfunction

  function void check_event(frame_event_t got);
    frame_event_t want;
    kind_seen[got.kind]++;
    if (pending_events.size() == 0) begin
      errors++;
      reported++;
      if (reported <= 10)
        $display("%0t: unexpected event kind %0d data %02h addr %02h index %0d", $time,
                 got.kind, got.data, got.addr, got.index);
      return;
    end
    want = pending_events.pop_front();
    if (got !== want) begin
      errors++;
      reported++;
      if (reported <= 10)
        $display({"%0t: mismatch: expected kind %0d data %02h addr %02h index %0d,",
                  " got kind %0d data %02h addr %02h index %0d"},
                 $time, want.kind, want.data, want.addr, want.index,
                 got.kind, got.data, got.addr, got.index);
    end
  endfunction

  function void finish_check();
    if (pending_events.size() != 0) begin
      errors += pending_events.size();
      $display("%0d expected events never arrived", pending_events.size());
    end
  endfunction
endclass

module testbench;

  localparam int unsigned ItemsTotal    = 1050;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned WatchdogLimit = 3000;

  // Hand-picked opening: noise while hunting, shortest good frame, the three
  // short lengths, and a frame with the sync value as data and a bad checksum.
  localparam logic [7:0] Opening [24] = '{
    8'h00, 8'hFF,
    slcd_pkg::SyncReset, 8'h03, 8'hFF, 8'h02,
    slcd_pkg::SyncReset, 8'h00, 8'h00, 8'h5A,
    slcd_pkg::SyncReset, 8'h01, 8'hAA, 8'h00,
    slcd_pkg::SyncReset, 8'h02, 8'h55, 8'hFF,
    slcd_pkg::SyncReset, 8'h05, 8'h00, slcd_pkg::SyncReset, 8'hFF, 8'h6D
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [slcd_pkg::ByteW-1:0] cfg_data;

  slcd_in_if  rx_if ();
  slcd_out_if ev_if ();

  sync_length_checksum_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .ev_o       (ev_if)
  );

  deframe_tracker tracker = new();

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned bytes_sent      = 0;
  int unsigned noise_sent      = 0;
  int unsigned frames_sent     = 0;
  logic [7:0]  sync_now        = slcd_pkg::SyncReset;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    ev_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin : event_monitor
    frame_event_t got;
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      got.kind  = ev_if.event_kind;
      got.data  = ev_if.payload_byte;
      got.addr  = ev_if.frame_address;
      got.index = ev_if.payload_index;
      tracker.check_event(got);
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WatchdogLimit);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    tracker.note_rx_byte(b);
    bytes_sent++;
  endtask

  // Sender holds off until every event has come out, then lets the pipe empty.
  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.sync_value = v;
    sync_now           = v;
  endtask

  task automatic send_frame(input logic [7:0] len, input bit bad_sum);
    logic [7:0] address;
    logic [7:0] sum;
    logic [7:0] p;
    int         n;
    address = 8'($urandom);
    sum     = len + address;
    n       = int'(len);
    send_byte(sync_now);
    send_byte(len);
    send_byte(address);
    if (n < 3) begin
      send_byte(8'($urandom));
    end else begin
      for (int i = 0; i < n - 3; i++) begin
        p   = 8'($urandom);
        sum = sum + p;
        send_byte(p);
      end
      send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
    frames_sent++;
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [7:0]  len;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Opening[i]) send_byte(Opening[i]);
    noise_sent += 2;

    // Four idling modes; a new sync value is written before each of the last three (the last one random).
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 86; end
        default: begin sender_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      if (ph == 1) write_sync(8'h00);
      else if (ph == 2) write_sync(8'hFF);
      else if (ph == 3) write_sync(8'($urandom));
      if (ph == 2) send_frame(8'd255, 1'b0);  // longest frame, payload index up to 251
      while (bytes_sent - noise_sent < (ph + 1) * ItemsTotal / 4) begin
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom));
            noise_sent++;
          end
        end
        pick = $urandom_range(99);
        if (pick < 10) len = 8'($urandom_range(0, 2));
        else if (pick < 80) len = 8'($urandom_range(3, 12));
        else if (pick < 98) len = 8'($urandom_range(13, 40));
        else len = 8'($urandom_range(41, 80));
        send_frame(len, $urandom_range(11) == 0);
      end
    end

    rx_if.valid <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    tracker.finish_check();

    $display("Covered %0d bytes (%0d noise) in %0d frames under four sync values %s",
             tracker.bytes_seen, noise_sent, frames_sent, "and idling modes");
    $display("Events seen: %0d payload, %0d accepted, %0d checksum errors, %0d sequence errors",
             tracker.kind_seen[slcd_pkg::EvPayload], tracker.kind_seen[slcd_pkg::EvAccept],
             tracker.kind_seen[slcd_pkg::EvChecksumErr],
             tracker.kind_seen[slcd_pkg::EvSequenceErr]);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
